### rtl/assert_macros.svh
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define HDTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked property that is also checked during reset
`define HDTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hdte_pkg.sv
// shared types, status codes and calendar tables of the date header decoder
`timescale 1ns / 1ps

package hdte_pkg;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_HDR  = 2'd1;
  localparam logic [1:0] STATUS_NO_EOL  = 2'd2;
  localparam logic [1:0] STATUS_BAD_FMT = 2'd3;

  localparam int NUM_MONTHS = 12;

  // month names, three ascii characters packed first-char-high
  localparam logic [23:0] MONTH_NAMES [NUM_MONTHS] = '{
    24'h4a616e, 24'h466562, 24'h4d6172, 24'h417072,
    24'h4d6179, 24'h4a756e, 24'h4a756c, 24'h417567,
    24'h536570, 24'h4f6374, 24'h4e6f76, 24'h446563
  };

  // days in the year before the first of each month, non-leap
  localparam logic [8:0] DAYS_BEFORE [NUM_MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // request from the scanner to the epoch calculator
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  month;   // 1..12, zero when the name is unknown
    logic [31:0] day;
    logic [31:0] year;
    logic [31:0] hour;
    logic [31:0] minute;
    logic [31:0] second;
  } job_t;

  // month name to 1..12, zero when no name matches
  function automatic logic [3:0] month_index(logic [23:0] name);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 0; i < NUM_MONTHS; i++) begin
      if (name == MONTH_NAMES[i]) begin
        idx = 4'(i + 1);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/hdte_front.sv
// byte scanner: header search, date field matching and request build
`timescale 1ns / 1ps

module hdte_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  output logic               job_valid_o,
  output hdte_pkg::job_t     job_o
);

  localparam logic [1:0] PH_SEARCH  = 2'd0;
  localparam logic [1:0] PH_TEXT    = 2'd1;
  localparam logic [1:0] PH_TEXT_CR = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [3:0] ST_WDAY  = 4'd0;
  localparam logic [3:0] ST_COMMA = 4'd1;
  localparam logic [3:0] ST_DAY   = 4'd2;
  localparam logic [3:0] ST_MON   = 4'd3;
  localparam logic [3:0] ST_YEAR  = 4'd4;
  localparam logic [3:0] ST_HOUR  = 4'd5;
  localparam logic [3:0] ST_COL1  = 4'd6;
  localparam logic [3:0] ST_MIN   = 4'd7;
  localparam logic [3:0] ST_COL2  = 4'd8;
  localparam logic [3:0] ST_SEC   = 4'd9;
  localparam logic [3:0] ST_STOP  = 4'd10;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_D     = 8'h44;

  localparam int HDR_LEN = 5;
  localparam int HDR_W   = $clog2(HDR_LEN + 1);
  localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{8'h44, 8'h61, 8'h74, 8'h65, 8'h3a};

  typedef struct packed {
    logic [3:0]  step;
    logic [1:0]  tlen;
    logic [23:0] month;
    logic [31:0] accum;
    logic        neg;
    logic [31:0] day;
    logic [31:0] year;
    logic [31:0] hour;
    logic [31:0] minute;
    logic        fields_done;
  } scan_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // one character through the pattern matcher; a field that ends on a
  // character hands that same character on to the next field
  function automatic scan_t feed(scan_t s_in, logic [7:0] c);
    scan_t       s;
    logic        again;
    logic        ws;
    logic        dig;
    logic [31:0] dval;
    logic [31:0] nval;
    s     = s_in;
    ws    = is_ws(c);
    dig   = (c >= CH_ZERO) && (c <= CH_NINE);
    dval  = {24'd0, c - CH_ZERO};
    nval  = 32'd0;
    again = 1'b1;
    for (int pass = 0; pass < 2; pass++) begin
      if (again) begin
        again = 1'b0;
        unique case (s.step)
          ST_WDAY, ST_MON: begin
            if (s.tlen == 2'd0) begin
              if (!ws) begin
                s.tlen = 2'd1;
                if (s.step == ST_MON) s.month = {16'd0, c};
              end
            end else if (!ws && s.tlen < 2'd3) begin
              s.tlen = s.tlen + 2'd1;
              if (s.step == ST_MON) s.month = {s.month[15:0], c};
            end else begin
              if (s.step == ST_WDAY) begin
                s.step = ST_COMMA;
                s.tlen = 2'd0;
              end else begin
                s.step  = ST_YEAR;
                s.tlen  = 2'd0;
                s.accum = 32'd0;
                s.neg   = 1'b0;
              end
              again = 1'b1;
            end
          end
          ST_COMMA, ST_COL1, ST_COL2: begin
            if (c == ((s.step == ST_COMMA) ? CH_COMMA : CH_COLON)) begin
              s.step  = s.step + 4'd1;
              s.tlen  = 2'd0;
              s.accum = 32'd0;
              s.neg   = 1'b0;
            end else begin
              s.step        = ST_STOP;
              s.fields_done = 1'b0;
            end
          end
          ST_DAY, ST_YEAR, ST_HOUR, ST_MIN, ST_SEC: begin
            if (s.tlen == 2'd0) begin
              if (!ws) begin
                if (c == CH_PLUS || c == CH_MINUS) begin
                  s.neg  = (c == CH_MINUS);
                  s.tlen = 2'd1;
                end else if (!dig) begin
                  s.step        = ST_STOP;
                  s.fields_done = 1'b0;
                end else begin
                  s.accum = dval;
                  s.tlen  = 2'd2;
                end
              end
            end else if (s.tlen == 2'd1) begin
              if (!dig) begin
                s.step        = ST_STOP;
                s.fields_done = 1'b0;
              end else begin
                s.accum = dval;
                s.tlen  = 2'd2;
              end
            end else if (dig) begin
              // times ten as two shifts
              s.accum = (s.accum << 3) + (s.accum << 1) + dval;
            end else begin
              nval = s.neg ? (32'd0 - s.accum) : s.accum;
              unique case (s.step)
                ST_DAY: begin
                  s.day   = nval;
                  s.step  = ST_MON;
                  s.tlen  = 2'd0;
                  s.month = 24'd0;
                end
                ST_YEAR: begin
                  s.year  = nval;
                  s.step  = ST_HOUR;
                  s.tlen  = 2'd0;
                  s.accum = 32'd0;
                  s.neg   = 1'b0;
                end
                ST_HOUR: begin
                  s.hour = nval;
                  s.step = ST_COL1;
                  s.tlen = 2'd0;
                end
                ST_MIN: begin
                  s.minute = nval;
                  s.step   = ST_COL2;
                  s.tlen   = 2'd0;
                end
                default: begin
                  s.step        = ST_STOP;
                  s.fields_done = 1'b1;
                end
              endcase
              again = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
    return s;
  endfunction

  logic [1:0]       phase_q, phase_d, phase_nx;
  logic [HDR_W-1:0] hdr_q, hdr_d;
  scan_t            scan_q, scan_d, scan_nx, scan_cr;
  logic             finish;
  logic             fmt_ok;

  // next state of the scanner for this byte
  always_comb begin
    phase_nx = phase_q;
    hdr_d    = hdr_q;
    scan_nx  = scan_q;
    scan_cr  = scan_q;
    finish   = 1'b0;
    unique case (phase_q)
      PH_SEARCH: begin
        if (hdr_q < HDR_W'(HDR_LEN) && ch_i == HDR_TEXT[hdr_q]) begin
          hdr_d = hdr_q + HDR_W'(1);
          if (hdr_q == HDR_W'(HDR_LEN - 1)) phase_nx = PH_TEXT;
        end else begin
          hdr_d = (ch_i == CH_D) ? HDR_W'(1) : HDR_W'(0);
        end
      end
      PH_TEXT: begin
        if (ch_i == CH_CR) phase_nx = PH_TEXT_CR;
        else scan_nx = feed(scan_q, ch_i);
      end
      PH_TEXT_CR: begin
        if (ch_i == CH_LF) begin
          finish   = 1'b1;
          phase_nx = PH_DONE;
        end else begin
          // a lone cr counts as whitespace of the date text
          scan_cr = feed(scan_q, CH_CR);
          if (ch_i != CH_CR) begin
            scan_nx  = feed(scan_cr, ch_i);
            phase_nx = PH_TEXT;
          end else begin
            scan_nx = scan_cr;
          end
        end
      end
      default: ;
    endcase
    // rearm after the final byte of a response
    phase_d = last_i ? PH_SEARCH : phase_nx;
    scan_d  = last_i ? '0 : scan_nx;
    if (last_i) hdr_d = '0;
  end

  // request to the calculator: at the line end, or at the final byte
  always_comb begin
    fmt_ok = scan_q.fields_done || (scan_q.step == ST_SEC && scan_q.tlen == 2'd2);
    job_valid_o   = byte_valid_i && (finish || (last_i && phase_q != PH_DONE));
    job_o.month   = hdte_pkg::month_index(scan_q.month);
    job_o.day     = scan_q.day;
    job_o.year    = scan_q.year;
    job_o.hour    = scan_q.hour;
    job_o.minute  = scan_q.minute;
    job_o.second  = scan_q.neg ? (32'd0 - scan_q.accum) : scan_q.accum;
    if (finish) begin
      job_o.status = fmt_ok ? hdte_pkg::STATUS_OK : hdte_pkg::STATUS_BAD_FMT;
    end else begin
      job_o.status = (phase_nx == PH_SEARCH) ? hdte_pkg::STATUS_NO_HDR
                                             : hdte_pkg::STATUS_NO_EOL;
    end
  end

  // scanner registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      hdr_q   <= '0;
      scan_q  <= '0;
    end else if (byte_valid_i) begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      scan_q  <= scan_d;
    end
  end

endmodule

### rtl/hdte_jobq.sv
// two-entry request queue between scanner and epoch calculator
`timescale 1ns / 1ps

module hdte_jobq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  input  hdte_pkg::job_t wr_data_i,
  output logic           full_o,
  output logic           rd_valid_o,
  output hdte_pkg::job_t rd_data_o,
  input  logic           rd_pop_i
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdte_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_wr && !do_rd) cnt_q <= cnt_q + CNT_W'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

### rtl/hdte_back.sv
// epoch calculator: sequenced over one shared multiplier, plus result register
`timescale 1ns / 1ps

module hdte_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  hdte_pkg::job_t job_i,
  output logic           job_pop_o,
  output logic           res_valid_o,
  output logic [31:0]    res_epoch_o,
  output logic [1:0]     res_status_o,
  output logic           res_month_valid_o,
  input  logic           res_pop_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVY  = 4'd1;
  localparam logic [3:0] S_DIVN  = 4'd2;
  localparam logic [3:0] S_YEARS = 4'd3;
  localparam logic [3:0] S_DAYS  = 4'd4;
  localparam logic [3:0] S_DSEC  = 4'd5;
  localparam logic [3:0] S_HOUR  = 4'd6;
  localparam logic [3:0] S_MIN   = 4'd7;
  localparam logic [3:0] S_SEC   = 4'd8;
  localparam logic [3:0] S_WR    = 4'd9;

  // x / 25 as (x * RECIP25) >> RECIP_SHIFT, exact for x below 2^32
  localparam logic [31:0] RECIP25     = 32'd1374389535;
  localparam int          RECIP_SHIFT = 35;
  localparam int          QUO_W       = 27;
  localparam logic [31:0] EPOCH_YEAR  = 32'd1970;
  localparam logic [31:0] LEAPS_1969  = 32'd477;
  localparam logic [31:0] DAYS_YEAR   = 32'd365;
  localparam logic [31:0] SECS_DAY    = 32'd86400;
  localparam logic [31:0] SECS_HOUR   = 32'd3600;
  localparam logic [31:0] SECS_MIN    = 32'd60;

  logic [3:0]       st_q, st_d;
  logic [3:0]       month_q;
  logic [31:0]      year_q, day_q, hour_q, min_q, sec_q;
  logic [63:0]      prod_q, prod_d;
  logic [QUO_W-1:0] qy_q, qy_d;
  logic [QUO_W-1:0] rn;
  logic [31:0]      leaps_q, leaps_d;
  logic [31:0]      base_q, base_d;
  logic [31:0]      days_q, days_d;
  logic [31:0]      acc_q, acc_d;
  logic [1:0]       pend_status_q, pend_status_d;
  logic             pend_mv_q, pend_mv_d;
  logic             load;
  logic [31:0]      mul_a, mul_b;
  logic [31:0]      absy, nq, yoff;
  logic             after_epoch, div25, leap_yr;
  logic [3:0]       midx;
  logic             out_valid_q;
  logic [31:0]      out_epoch_q;
  logic [1:0]       out_status_q;
  logic             out_mv_q;
  logic             out_wr;

  // year terms used across the sequence
  always_comb begin
    absy        = year_q[31] ? (32'd0 - year_q) : year_q;
    nq          = (year_q - 32'd1) >> 2;
    yoff        = year_q - EPOCH_YEAR;
    after_epoch = $signed(year_q) > $signed(EPOCH_YEAR);
    rn          = prod_q[RECIP_SHIFT +: QUO_W];
    div25       = (absy == (32'(qy_q) * 32'd25));
    leap_yr     = ((year_q[1:0] == 2'd0) && !div25) || ((year_q[3:0] == 4'd0) && div25);
    midx        = month_q - 4'd1;
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (st_q)
      S_DIVY:  begin mul_a = absy;   mul_b = RECIP25;   end
      S_DIVN:  begin mul_a = nq;     mul_b = RECIP25;   end
      S_YEARS: begin mul_a = yoff;   mul_b = DAYS_YEAR; end
      S_DSEC:  begin mul_a = days_q; mul_b = SECS_DAY;  end
      S_HOUR:  begin mul_a = hour_q; mul_b = SECS_HOUR; end
      S_MIN:   begin mul_a = min_q;  mul_b = SECS_MIN;  end
      default: ;
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  // sequencer
  always_comb begin
    st_d          = st_q;
    qy_d          = qy_q;
    leaps_d       = leaps_q;
    base_d        = base_q;
    days_d        = days_q;
    acc_d         = acc_q;
    pend_status_d = pend_status_q;
    pend_mv_d     = pend_mv_q;
    load          = 1'b0;
    out_wr        = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (job_valid_i) begin
          load = 1'b1;
          if (job_i.status != hdte_pkg::STATUS_OK || job_i.month == 4'd0) begin
            // failure or unknown month: zero epoch, month flag low
            acc_d         = 32'd0;
            pend_status_d = job_i.status;
            pend_mv_d     = 1'b0;
            st_d          = S_WR;
          end else begin
            pend_status_d = hdte_pkg::STATUS_OK;
            pend_mv_d     = 1'b1;
            st_d          = S_DIVY;
          end
        end
      end
      S_DIVY: st_d = S_DIVN;
      S_DIVN: begin
        qy_d = prod_q[RECIP_SHIFT +: QUO_W];
        st_d = S_YEARS;
      end
      S_YEARS: begin
        // leap days since the epoch year, by the gregorian rule
        leaps_d = nq - 32'(rn) + 32'(rn >> 2) - LEAPS_1969;
        base_d  = 32'(hdte_pkg::DAYS_BEFORE[midx]) + 32'(leap_yr && month_q > 4'd2)
                + day_q - 32'd1;
        st_d    = S_DAYS;
      end
      S_DAYS: begin
        days_d = (after_epoch ? (prod_q[31:0] + leaps_q) : 32'd0) + base_q;
        st_d   = S_DSEC;
      end
      S_DSEC: st_d = S_HOUR;
      S_HOUR: begin
        acc_d = prod_q[31:0];
        st_d  = S_MIN;
      end
      S_MIN: begin
        acc_d = acc_q + prod_q[31:0];
        st_d  = S_SEC;
      end
      S_SEC: begin
        acc_d = acc_q + prod_q[31:0] + sec_q;
        st_d  = S_WR;
      end
      S_WR: begin
        if (!out_valid_q) begin
          out_wr = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign job_pop_o = load;

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q        <= prod_d;
    qy_q          <= qy_d;
    leaps_q       <= leaps_d;
    base_q        <= base_d;
    days_q        <= days_d;
    acc_q         <= acc_d;
    pend_status_q <= pend_status_d;
    pend_mv_q     <= pend_mv_d;
    if (load) begin
      month_q <= job_i.month;
      year_q  <= job_i.year;
      day_q   <= job_i.day;
      hour_q  <= job_i.hour;
      min_q   <= job_i.minute;
      sec_q   <= job_i.second;
    end
    if (out_wr) begin
      out_epoch_q  <= acc_q;
      out_status_q <= pend_status_q;
      out_mv_q     <= pend_mv_q;
    end
  end

  // control state and result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_wr) out_valid_q <= 1'b1;
      else if (res_pop_i) out_valid_q <= 1'b0;
    end
  end

  assign res_valid_o       = out_valid_q;
  assign res_epoch_o       = out_epoch_q;
  assign res_status_o      = out_status_q;
  assign res_month_valid_o = out_mv_q;

endmodule

### rtl/http_date_header_to_epoch_core.sv
// top level of the http date header to unix time decoder
//
//   channel | direction | handshake        | payload
//   bytes   | in        | push / full      | ch_i, last_i
//   results | out       | empty / pop      | epoch_seconds_o, status_o, month_valid_o
//
// the scanner takes one response byte per cycle while full is low
// full rises only when two requests already wait for the calculator
// the calculator steps a good date through its states over one shared multiplier,
// while a failure or an unknown month goes straight to the result write
// a finished result waits in the result register until popped
// reset is asynchronous and clears every control register, no clearing pass
`timescale 1ns / 1ps

module http_date_header_to_epoch_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] epoch_seconds_o,
  output logic [1:0]  status_o,
  output logic        month_valid_o
);

  logic           byte_valid;
  logic           fq_valid;
  hdte_pkg::job_t fq_data;
  logic           bq_valid;
  hdte_pkg::job_t bq_data;
  logic           bq_pop;
  logic           res_valid;

  assign byte_valid = push && !full;

  // byte scanner
  hdte_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .ch_i         (ch_i),
    .last_i       (last_i),
    .job_valid_o  (fq_valid),
    .job_o        (fq_data)
  );

  // request queue
  hdte_jobq u_jobq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_data_i  (fq_data),
    .full_o     (full),
    .rd_valid_o (bq_valid),
    .rd_data_o  (bq_data),
    .rd_pop_i   (bq_pop)
  );

  // epoch calculator
  hdte_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (bq_valid),
    .job_i             (bq_data),
    .job_pop_o         (bq_pop),
    .res_valid_o       (res_valid),
    .res_epoch_o       (epoch_seconds_o),
    .res_status_o      (status_o),
    .res_month_valid_o (month_valid_o),
    .res_pop_i         (pop)
  );

  assign empty = !res_valid;

endmodule

### rtl/hdte_checker.sv
// port-level checker for the date header decoder, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hdte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [31:0] epoch_seconds_o,
  input logic [1:0]  status_o,
  input logic        month_valid_o
);

  // a failed result carries no time and no month
  `HDTE_ASSERT(a_fail_zero, clk_i, rst_ni, (!empty && status_o != hdte_pkg::STATUS_OK) |-> (epoch_seconds_o == 32'd0 && !month_valid_o), "failure result with nonzero payload")

  // a recognised month only comes with a good status
  `HDTE_ASSERT(a_month_ok, clk_i, rst_ni, (!empty && month_valid_o) |-> (status_o == hdte_pkg::STATUS_OK), "month flag on failed result")

  // a waiting result holds until popped
  `HDTE_ASSERT(a_hold, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(epoch_seconds_o) && $stable(status_o) && $stable(month_valid_o)), "waiting result changed")

  // the result register stays empty in the cycle after a pop
  `HDTE_ASSERT(a_pop_gap, clk_i, rst_ni, (!empty && pop) |=> empty, "result register refilled on pop")

  // nothing is offered while reset is held
  `HDTE_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> empty, "result offered during reset")

endmodule

bind http_date_header_to_epoch_core hdte_checker u_hdte_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .empty           (empty),
  .pop             (pop),
  .epoch_seconds_o (epoch_seconds_o),
  .status_o        (status_o),
  .month_valid_o   (month_valid_o)
);

### dv/http_date_header_to_epoch_core_tb.sv
// self-checking testbench for the http date header to unix time decoder
`timescale 1ns / 1ps

module http_date_header_to_epoch_core_tb;
  import hdte_pkg::*;

  localparam int unsigned RUN_LIMIT  = 200000;
  localparam int unsigned ITEM_GOAL  = 1150;
  localparam int unsigned RESP_GOAL  = 20;
  localparam int unsigned DRAIN_WAIT = 64;
  localparam int unsigned CALM_FROM  = 1000;
  localparam int unsigned CALM_TO    = 1600;

  localparam bit [7:0] CR_CHAR = 8'h0d;
  localparam bit [7:0] LF_CHAR = 8'h0a;
  localparam bit [7:0] TAG_CHARS [5] = '{"D", "a", "t", "e", ":"};
  // leap days up to the end of 1969, removed from the closed-form count
  localparam longint LEAPS_TO_1969 = 1969 / 4 - 1969 / 100 + 1969 / 400;

  // scanner phase and scanf pattern position
  typedef enum logic [1:0] {SCAN_HUNT, SCAN_TEXT, SCAN_TEXT_CR, SCAN_DONE} scan_phase_e;
  typedef enum logic [3:0] {
    FLD_WDAY, FLD_COMMA, FLD_DAY, FLD_MON, FLD_YEAR, FLD_HOUR,
    FLD_COL1, FLD_MIN, FLD_COL2, FLD_SEC, FLD_STOP
  } field_e;

  typedef struct {
    bit [7:0] ch;
    bit       last;
  } byte_req_t;

  typedef struct {
    bit [31:0] epoch;
    bit [1:0]  status;
    bit        month_ok;
  } stamp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  byte_in = 8'h00;
  logic        last_in = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] epoch_seconds_o;
  logic [1:0]  status_o;
  logic        month_valid_o;

  byte_req_t   bytes_pending [$];
  byte_req_t   next_req;
  bit [7:0]    resp_buf [$];
  stamp_t      stamps_due [$];
  stamp_t      want;

  int unsigned cycles = 0;
  int unsigned responses_built = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};

  string WEEKDAYS [7] = '{"Mon", "Tue", "Wed", "Thu", "Fri", "Sat", "Sun"};
  int unsigned YEAR_EDGES [12] = '{
    0, 1969, 1970, 1971, 1972, 2000, 2038, 2100, 2106, 2400, 2147483647, 4000000000
  };

  http_date_header_to_epoch_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .ch_i           (byte_in),
    .last_i         (last_in),
    .empty          (empty),
    .pop            (pop),
    .epoch_seconds_o(epoch_seconds_o),
    .status_o       (status_o),
    .month_valid_o  (month_valid_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // decoder prediction
  // ---------------------------------------------------------------------------
  scan_phase_e scan_ph;
  field_e      fstep;
  bit [2:0]    tag_pos;
  bit [1:0]    tok_len;
  bit [23:0]   mon_chars;
  bit [31:0]   num_acc;
  bit          num_neg;
  bit [31:0]   day_v, year_v, hour_v, min_v;
  bit          fields_ok;
  bit          stamp_sent;

  function automatic void clear_scan();
    scan_ph    = SCAN_HUNT;
    fstep      = FLD_WDAY;
    tag_pos    = '0;
    tok_len    = '0;
    mon_chars  = '0;
    num_acc    = '0;
    num_neg    = 1'b0;
    day_v      = '0;
    year_v     = '0;
    hour_v     = '0;
    min_v      = '0;
    fields_ok  = 1'b0;
    stamp_sent = 1'b0;
  endfunction

  function automatic bit is_space(input bit [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void open_number(input field_e nxt);
    fstep   = nxt;
    tok_len = '0;
    num_acc = '0;
    num_neg = 1'b0;
  endfunction

  function automatic void halt_fail();
    fstep     = FLD_STOP;
    fields_ok = 1'b0;
  endfunction

  function automatic bit [31:0] num_value();
    return num_neg ? (32'd0 - num_acc) : num_acc;
  endfunction

  function automatic void post_stamp(input bit [31:0] epoch, input bit [1:0] status,
                                     input bit month_ok);
    stamp_t s;
    s.epoch    = epoch;
    s.status   = status;
    s.month_ok = month_ok;
    stamps_due.push_back(s);
    stamp_sent = 1'b1;
    scan_ph    = SCAN_DONE;
  endfunction

  // streaming match of one date text character against the scanf pattern
  function automatic void feed_date_char(input bit [7:0] c);
    bit again;
    bit is_dig;
    again = 1'b1;
    while (again) begin
      again  = 1'b0;
      is_dig = c >= "0" && c <= "9";
      case (fstep)
        // three character tokens, weekday and month
        FLD_WDAY, FLD_MON: begin
          if (tok_len == 0) begin
            if (!is_space(c)) begin
              tok_len = 1;
              if (fstep == FLD_MON) mon_chars = {16'd0, c};
            end
          end else if (!is_space(c) && tok_len < 3) begin
            tok_len++;
            if (fstep == FLD_MON) mon_chars = {mon_chars[15:0], c};
          end else begin
            if (fstep == FLD_WDAY) begin
              fstep   = FLD_COMMA;
              tok_len = '0;
            end else begin
              open_number(FLD_YEAR);
            end
            again = 1'b1;
          end
        end
        // literal separators
        FLD_COMMA, FLD_COL1, FLD_COL2: begin
          if ((fstep == FLD_COMMA && c == ",") || (fstep != FLD_COMMA && c == ":")) begin
            open_number(field_e'(fstep + 1));
          end else begin
            halt_fail();
          end
        end
        // signed decimal numbers
        FLD_DAY, FLD_YEAR, FLD_HOUR, FLD_MIN, FLD_SEC: begin
          if (tok_len == 0) begin
            if (is_space(c)) begin
            end else if (c == "+" || c == "-") begin
              num_neg = (c == "-");
              tok_len = 1;
            end else if (!is_dig) begin
              halt_fail();
            end else begin
              num_acc = c - 8'h30;
              tok_len = 2;
            end
          end else if (tok_len == 1) begin
            if (!is_dig) begin
              halt_fail();
            end else begin
              num_acc = c - 8'h30;
              tok_len = 2;
            end
          end else if (is_dig) begin
            num_acc = num_acc * 10 + (c - 8'h30);
          end else begin
            case (fstep)
              FLD_DAY: begin
                day_v     = num_value();
                fstep     = FLD_MON;
                tok_len   = '0;
                mon_chars = '0;
              end
              FLD_YEAR: begin
                year_v = num_value();
                open_number(FLD_HOUR);
              end
              FLD_HOUR: begin
                hour_v  = num_value();
                fstep   = FLD_COL1;
                tok_len = '0;
              end
              FLD_MIN: begin
                min_v   = num_value();
                fstep   = FLD_COL2;
                tok_len = '0;
              end
              default: begin
                fstep     = FLD_STOP;
                fields_ok = 1'b1;
              end
            endcase
            again = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  // line end seen: convert the matched fields to seconds since 1970
  function automatic void close_line();
    longint          y, n, d, dd, h, mi, sc;
    longint unsigned days, secs;
    int              mon;
    bit              ok;
    ok = fields_ok || (fstep == FLD_SEC && tok_len == 2);
    if (!ok) begin
      post_stamp('0, STATUS_BAD_FMT, 1'b0);
      return;
    end
    mon = 0;
    for (int i = 0; i < NUM_MONTHS; i++) begin
      if (mon_chars == MONTH_NAMES[i]) mon = i + 1;
    end
    if (mon == 0) begin
      post_stamp('0, STATUS_OK, 1'b0);
      return;
    end
    y    = $signed(year_v);
    dd   = $signed(day_v);
    h    = $signed(hour_v);
    mi   = $signed(min_v);
    sc   = $signed(num_value());
    days = 0;
    if (y > 1970) begin
      n    = y - 1;
      d    = 365 * (y - 1970) + (n / 4 - n / 100 + n / 400) - LEAPS_TO_1969;
      days = d;
    end
    days += DAYS_BEFORE[mon - 1];
    if (mon > 2 && ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0)) days += 1;
    days += dd - 1;
    secs = days * 86400 + h * 3600 + mi * 60 + sc;
    post_stamp(secs[31:0], STATUS_OK, 1'b1);
  endfunction

  // one accepted response byte
  function automatic void date_scan_step(input bit [7:0] c, input bit last);
    case (scan_ph)
      SCAN_HUNT: begin
        if (tag_pos < 5 && c == TAG_CHARS[tag_pos]) begin
          tag_pos++;
          if (tag_pos == 5) scan_ph = SCAN_TEXT;
        end else begin
          tag_pos = (c == "D") ? 3'd1 : 3'd0;
        end
      end
      SCAN_TEXT: begin
        if (c == CR_CHAR) scan_ph = SCAN_TEXT_CR;
        else feed_date_char(c);
      end
      SCAN_TEXT_CR: begin
        if (c == LF_CHAR) begin
          close_line();
        end else begin
          feed_date_char(CR_CHAR);
          if (c != CR_CHAR) begin
            feed_date_char(c);
            scan_ph = SCAN_TEXT;
          end
        end
      end
      default: begin
      end
    endcase
    if (last) begin
      if (!stamp_sent) post_stamp('0, (scan_ph == SCAN_HUNT) ? STATUS_NO_HDR : STATUS_NO_EOL, 1'b0);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // response builders
  // ---------------------------------------------------------------------------
  task automatic put_byte(input bit [7:0] b);
    resp_buf.push_back(b);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) resp_buf.push_back(s[i]);
  endtask

  task automatic put_eol();
    put_byte(CR_CHAR);
    put_byte(LF_CHAR);
  endtask

  // whitespace run, now and then a tab, lf, vt, ff or lone cr
  task automatic put_space(input int unsigned least);
    int unsigned n, r;
    n = least + (($urandom_range(0, 9) == 0) ? 1 : 0);
    repeat (n) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        put_byte(" ");
      end else if (r < 18) begin
        put_byte(8'(9 + $urandom_range(0, 3)));
      end else begin
        put_byte(CR_CHAR);
        put_byte(" ");
      end
    end
  endtask

  // decimal field with optional sign, overflowing digit runs or a missing value
  task automatic put_number(input int unsigned lo, input int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      put_byte("-");
    end else if (r < 9) begin
      put_byte("+");
    end else if (r < 11) begin
      put_byte("+");
      put_byte(" ");
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      repeat ($urandom_range(10, 14)) put_byte(8'("0" + $urandom_range(0, 9)));
    end else if (r < 7) begin
      put_byte("x");
    end else begin
      put_text($sformatf("%0d", $urandom_range(lo, hi)));
    end
  endtask

  task automatic put_date_line();
    int unsigned r, k;
    put_text("Date:");
    put_space(0);
    // weekday token
    if ($urandom_range(0, 99) < 85) begin
      put_text(WEEKDAYS[$urandom_range(0, 6)]);
    end else begin
      repeat ($urandom_range(1, 5)) put_byte(8'($urandom_range(0, 255)));
    end
    put_byte(($urandom_range(0, 99) < 95) ? 8'(",") : 8'($urandom_range(0, 255)));
    put_space(1);
    put_number(1, 31);
    put_space(1);
    // month token
    r = $urandom_range(0, 99);
    k = $urandom_range(0, NUM_MONTHS - 1);
    if (r < 82) begin
      put_byte(MONTH_NAMES[k][23:16]);
      put_byte(MONTH_NAMES[k][15:8]);
      put_byte(MONTH_NAMES[k][7:0]);
    end else if (r < 90) begin
      repeat (3) put_byte(8'($urandom_range(65, 122)));
    end else if (r < 95) begin
      put_byte(MONTH_NAMES[k][23:16]);
      put_byte(MONTH_NAMES[k][15:8]);
    end else begin
      put_byte(MONTH_NAMES[k][23:16]);
      put_byte(MONTH_NAMES[k][15:8]);
      put_byte(MONTH_NAMES[k][7:0]);
      put_byte("t");
    end
    put_space(1);
    if ($urandom_range(0, 99) < 20) put_text($sformatf("%0d", YEAR_EDGES[$urandom_range(0, 11)]));
    else put_number(1950, 2110);
    put_space(1);
    // hh:mm:ss
    put_number(0, 23);
    put_byte(($urandom_range(0, 99) < 97) ? 8'(":") : 8'($urandom_range(0, 255)));
    put_number(0, 59);
    put_byte(($urandom_range(0, 99) < 97) ? 8'(":") : 8'($urandom_range(0, 255)));
    put_number(0, 60);
    if ($urandom_range(0, 99) < 80) put_text(" GMT");
  endtask

  // move the built response to the request queue, last on its final byte
  task automatic close_response();
    byte_req_t r;
    while (resp_buf.size() != 0) begin
      r.ch   = resp_buf.pop_front();
      r.last = (resp_buf.size() == 0);
      bytes_pending.push_back(r);
    end
    responses_built++;
  endtask

  task automatic build_random_response();
    int unsigned kind, r, cut;
    kind = $urandom_range(0, 99);
    if (kind < 7) begin
      // pure noise, often with header-like starts
      repeat ($urandom_range(1, 12)) begin
        put_byte(($urandom_range(0, 3) == 0) ? 8'("D") : 8'($urandom_range(0, 255)));
      end
    end else begin
      // partial header matches ahead of the real one
      case ($urandom_range(0, 9))
        0: put_text("D");
        1: put_text("Da");
        2: put_text("DDat");
        3: put_text("Date");
        4: begin
          put_text("OK");
          put_eol();
        end
        default: begin
        end
      endcase
      put_date_line();
      // line end, doubled cr, lone cr or none
      r = $urandom_range(0, 99);
      if (r < 82) begin
        put_eol();
      end else if (r < 88) begin
        put_byte(CR_CHAR);
        put_eol();
      end else if (r < 92) begin
        put_byte(CR_CHAR);
        put_byte("x");
        put_eol();
      end
      // bytes after the line end
      if ($urandom_range(0, 9) == 0) put_text("Date:");
      repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 6) begin
        resp_buf[$urandom_range(0, resp_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end
      // response cut short
      if (kind >= 92) begin
        cut = $urandom_range(1, resp_buf.size());
        while (resp_buf.size() > cut) void'(resp_buf.pop_back());
      end
    end
    close_response();
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni <= 1'b0;
    clear_scan();

    // bytes with no header at all, extremes of the byte value
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte("D");
    close_response();
    // header with an empty line
    put_text("Date:");
    put_eol();
    close_response();
    // the epoch itself, last on the line feed
    put_text("Date:Thu,1 Jan 1970 0:0:0");
    put_eol();
    close_response();
    // header but the response ends before any line end
    put_text("Date:x");
    close_response();

    while (bytes_pending.size() < ITEM_GOAL || responses_built < RESP_GOAL) begin
      build_random_response();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_pending.size() != 0 || push || stamps_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d responses in %0d bytes; %0d results checked", responses_built, bytes_taken,
             results_seen);
    $display("status ok %0d, no header %0d, no line end %0d, bad format %0d; mismatches %0d",
             status_seen[STATUS_OK], status_seen[STATUS_NO_HDR], status_seen[STATUS_NO_EOL],
             status_seen[STATUS_BAD_FMT], mismatches);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // random idle cycles, none inside the calm window
  function automatic bit take_break();
    if (cycles >= CALM_FROM && cycles < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 16;
  endfunction

  // cycle count and run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("run limit of %0d cycles reached", RUN_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        date_scan_step(byte_in, last_in);
        bytes_taken++;
      end
      if (!push || !full) begin
        if (bytes_pending.size() != 0 && !take_break()) begin
          next_req = bytes_pending.pop_front();
          push    <= 1'b1;
          byte_in <= next_req.ch;
          last_in <= next_req.last;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string field, input bit [31:0] expd,
                                      input logic [31:0] actual);
    if (actual !== expd) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d %s: expected %0d, got %0d", results_seen, field, expd, actual);
      end
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        status_seen[status_o]++;
        if (stamps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: epoch %0d status %0d month_valid %0d",
                     epoch_seconds_o, status_o, month_valid_o);
          end
        end else begin
          want = stamps_due.pop_front();
          check_field("epoch_seconds", want.epoch, epoch_seconds_o);
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("month_valid", 32'(want.month_ok), 32'(month_valid_o));
        end
        results_seen++;
      end
      pop <= !take_break();
    end
  end

endmodule
